/* sv/assert_macros.svh */
// assertion helpers, sampled on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle
`define OTSM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent must hold in the next cycle
`define OTSM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/otsm_pkg.sv */
package otsm_pkg;

  localparam int CalW    = 12;
  localparam int TempW   = 9;
  localparam int RunW    = 8;
  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CfgCal30   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCal110  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgTrip    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRelease = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgConfirm = 3'd4;

  localparam logic [CalW-1:0]         Cal30Rst   = 12'd1750;
  localparam logic [CalW-1:0]         Cal110Rst  = 12'd1310;
  localparam logic signed [TempW-1:0] TripRst    = 9'sd60;
  localparam logic signed [TempW-1:0] ReleaseRst = 9'sd55;
  localparam logic [RunW-1:0]         ConfirmRst = 8'd5;

  // temperature of the lower calibration point
  localparam logic signed [TempW-1:0] TempBase = 9'sd30;

  typedef enum logic [2:0] {
    StIdle,
    StCalc,
    StStart,
    StDiv,
    StFin
  } state_e;

  typedef struct packed {
    logic shutdown;
    logic clear_torque;
  } hyst_res_t;

endpackage

/* sv/overtemp_shutdown_monitor.sv */
// per accepted word the sequencer steps through calibrate, divider start, the divider bit
//   loop (one quotient bit per cycle) and finish; a zero calibration span skips the divider
// a new word is taken only once the previous one has left the finish state
// a finished result waits in the output register while the next word is taken
// reset clears the run counters, shutdown state and loads configuration defaults
module overtemp_shutdown_monitor #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [otsm_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [otsm_pkg::CalW-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [SAMPLE_BITS-1:0]              sensor_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [otsm_pkg::TempW-1:0]   temp_celsius_o,
  output logic                                shutdown_o,
  output logic                                clear_torque_o
);

  localparam int CalW  = otsm_pkg::CalW;
  localparam int TempW = otsm_pkg::TempW;
  localparam int RunW  = otsm_pkg::RunW;
  localparam int DiffW = ((SAMPLE_BITS > CalW) ? SAMPLE_BITS : CalW) + 1;
  localparam int NumW  = DiffW + 7;
  localparam int MagW  = NumW - 1;
  localparam int SumW  = TempW + 2;

  logic [CalW-1:0]         cal30_q, cal110_q;
  logic signed [TempW-1:0] trip_q, release_q;
  logic [RunW-1:0]         confirm_q;

  otsm_pkg::state_e state_q, state_d;

  logic [SAMPLE_BITS-1:0] sample_q;
  logic [MagW-1:0]        num_mag_q;
  logic [CalW-1:0]        span_mag_q;
  logic                   neg_q;
  logic                   span_zero_q;

  logic                   in_ready;
  logic                   calc_en;
  logic                   div_start;
  logic                   cap;
  logic                   div_done;
  logic [MagW-1:0]        quo;

  logic signed [DiffW-1:0] diff;
  logic signed [NumW-1:0]  num;
  logic [NumW-1:0]         num_abs;
  logic signed [CalW:0]    span;
  logic [CalW:0]           span_abs;

  logic [TempW-1:0]        q_sat;
  logic signed [SumW-1:0]  q_signed;
  logic signed [SumW-1:0]  t_sum;
  logic signed [TempW-1:0] temp;

  otsm_pkg::hyst_res_t hyst_res;

  logic                    out_valid_q;
  logic signed [TempW-1:0] temp_out_q;
  logic                    sd_out_q;
  logic                    clr_out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal30_q   <= otsm_pkg::Cal30Rst;
      cal110_q  <= otsm_pkg::Cal110Rst;
      trip_q    <= otsm_pkg::TripRst;
      release_q <= otsm_pkg::ReleaseRst;
      confirm_q <= otsm_pkg::ConfirmRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        otsm_pkg::CfgCal30:   cal30_q   <= cfg_wdata_i;
        otsm_pkg::CfgCal110:  cal110_q  <= cfg_wdata_i;
        otsm_pkg::CfgTrip:    trip_q    <= cfg_wdata_i[TempW-1:0];
        otsm_pkg::CfgRelease: release_q <= cfg_wdata_i[TempW-1:0];
        otsm_pkg::CfgConfirm: confirm_q <= cfg_wdata_i[RunW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      otsm_pkg::StIdle:  if (in_valid_i) state_d = otsm_pkg::StCalc;
      otsm_pkg::StCalc:  state_d = (span == '0) ? otsm_pkg::StFin : otsm_pkg::StStart;
      otsm_pkg::StStart: state_d = otsm_pkg::StDiv;
      otsm_pkg::StDiv:   if (div_done) state_d = otsm_pkg::StFin;
      otsm_pkg::StFin:   if (!out_valid_q || out_ready_i) state_d = otsm_pkg::StIdle;
      default:           state_d = otsm_pkg::StIdle;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    calc_en   = 1'b0;
    div_start = 1'b0;
    cap       = 1'b0;
    unique case (state_q)
      otsm_pkg::StIdle:  in_ready  = 1'b1;
      otsm_pkg::StCalc:  calc_en   = 1'b1;
      otsm_pkg::StStart: div_start = 1'b1;
      otsm_pkg::StDiv:   ;
      otsm_pkg::StFin:   cap       = !out_valid_q || out_ready_i;
      default:           ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= otsm_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // (sample - cal30) * 80 as two shifted adds, split into sign and magnitude
  always_comb begin
    diff     = DiffW'(sample_q) - DiffW'(cal30_q);
    num      = (NumW'(diff) <<< 6) + (NumW'(diff) <<< 4);
    num_abs  = num[NumW-1] ? NumW'(-num) : NumW'(num);
    span     = (CalW+1)'(cal110_q) - (CalW+1)'(cal30_q);
    span_abs = span[CalW] ? (CalW+1)'(-span) : (CalW+1)'(span);
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      sample_q <= sensor_sample_i;
    end
    if (calc_en) begin
      num_mag_q   <= num_abs[MagW-1:0];
      span_mag_q  <= span_abs[CalW-1:0];
      neg_q       <= num[NumW-1] ^ span[CalW];
      span_zero_q <= (span == '0);
    end
  end

  otsm_div #(
    .MagW(MagW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num_mag_q),
    .divisor_i  (span_mag_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // apply sign, add base, saturate; a zero span gives the base temperature
  always_comb begin
    q_sat    = (|quo[MagW-1:TempW]) ? '1 : quo[TempW-1:0];
    q_signed = neg_q ? -SumW'(q_sat) : SumW'(q_sat);
    t_sum    = q_signed + SumW'(otsm_pkg::TempBase);
    if (span_zero_q) begin
      temp = otsm_pkg::TempBase;
    end else if (t_sum > SumW'(255)) begin
      temp = 9'sd255;
    end else if (t_sum < -SumW'(256)) begin
      temp = -9'sd256;
    end else begin
      temp = t_sum[TempW-1:0];
    end
  end

  otsm_hyst u_hyst (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .upd_i     (cap),
    .temp_i    (temp),
    .trip_i    (trip_q),
    .release_i (release_q),
    .confirm_i (confirm_q),
    .res_o     (hyst_res)
  );

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cap) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap) begin
      temp_out_q <= temp;
      sd_out_q   <= hyst_res.shutdown;
      clr_out_q  <= hyst_res.clear_torque;
    end
  end

  assign in_ready_o     = in_ready;
  assign out_valid_o    = out_valid_q;
  assign temp_celsius_o = temp_out_q;
  assign shutdown_o     = sd_out_q;
  assign clear_torque_o = clr_out_q;

  `include "assert_macros.svh"

  `OTSM_ASSERT_NXT(a_acc_busy, in_valid_i && in_ready, !in_ready)
  `OTSM_ASSERT_NXT(a_cap_out, cap, out_valid_q)
  `OTSM_ASSERT_NOW(a_done_in_div, div_done, state_q == otsm_pkg::StDiv)
  `OTSM_ASSERT_NOW(a_clr_sets_sd, cap && hyst_res.clear_torque && temp >= release_q,
                   hyst_res.shutdown)

endmodule

/* sv/otsm_div.sv */
module otsm_div #(
  parameter int MagW = 19
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [MagW-1:0]           dividend_i,
  input  logic [otsm_pkg::CalW-1:0] divisor_i,
  output logic                      done_o,
  output logic [MagW-1:0]           quotient_o
);

  localparam int CntW = $clog2(MagW + 1);
  localparam int CalW = otsm_pkg::CalW;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [MagW-1:0] quo_q, quo_d;
  logic [CalW-1:0] rem_q, rem_d;
  logic [CalW-1:0] div_q, div_d;
  logic [CalW:0]   rem_sh;
  logic [CalW:0]   rem_sub;
  logic            qbit;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_sh  = {rem_q, quo_q[MagW-1]};
    rem_sub = rem_sh - {1'b0, div_q};
    qbit    = (rem_sh >= {1'b0, div_q});
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    div_d   = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(MagW);
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[MagW-2:0], qbit};
      rem_d = qbit ? rem_sub[CalW-1:0] : rem_sh[CalW-1:0];
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  `include "assert_macros.svh"

  `OTSM_ASSERT_NXT(a_start_busy, start_i, busy_q)
  `OTSM_ASSERT_NOW(a_done_idle, done_q, !busy_q)
  `OTSM_ASSERT_NOW(a_busy_cnt, busy_q, cnt_q != '0)

endmodule

/* sv/otsm_hyst.sv */
module otsm_hyst (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             upd_i,
  input  logic signed [otsm_pkg::TempW-1:0] temp_i,
  input  logic signed [otsm_pkg::TempW-1:0] trip_i,
  input  logic signed [otsm_pkg::TempW-1:0] release_i,
  input  logic [otsm_pkg::RunW-1:0]        confirm_i,
  output otsm_pkg::hyst_res_t              res_o
);

  localparam int RunW = otsm_pkg::RunW;

  logic [RunW-1:0] hot_q, hot_d, hot_inc;
  logic [RunW-1:0] cool_q, cool_d, cool_inc;
  logic            sd_q, sd_d;
  logic            clr;

  always_comb begin
    hot_inc  = (hot_q == '1) ? hot_q : hot_q + RunW'(1);
    cool_inc = (cool_q == '1) ? cool_q : cool_q + RunW'(1);
    sd_d     = sd_q;
    clr      = 1'b0;
    hot_d    = '0;
    cool_d   = '0;
    if (temp_i > trip_i) begin
      hot_d = hot_inc;
      if (hot_inc > confirm_i) begin
        sd_d = 1'b1;
        clr  = 1'b1;
      end
    end
    // cool rule applies after the hot rule
    if (temp_i < release_i) begin
      cool_d = cool_inc;
      if (cool_inc > confirm_i) begin
        sd_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hot_q  <= '0;
      cool_q <= '0;
      sd_q   <= 1'b0;
    end else if (upd_i) begin
      hot_q  <= hot_d;
      cool_q <= cool_d;
      sd_q   <= sd_d;
    end
  end

  assign res_o.shutdown     = sd_d;
  assign res_o.clear_torque = clr;

  `include "assert_macros.svh"

  `OTSM_ASSERT_NXT(a_hold_sd, !upd_i, $stable(sd_q))
  `OTSM_ASSERT_NOW(a_clr_hot, clr, temp_i > trip_i)
  `OTSM_ASSERT_NXT(a_runs_excl, upd_i && temp_i >= release_i, cool_q == '0)

endmodule

/* tb/sv/overtemp_shutdown_monitor_test.sv */
module overtemp_shutdown_monitor_test;

  localparam int CalW    = otsm_pkg::CalW;
  localparam int TempW   = otsm_pkg::TempW;
  localparam int RunW    = otsm_pkg::RunW;
  localparam int CfgIdxW = otsm_pkg::CfgIdxW;

  localparam int SampleW       = 12;
  localparam int CalSpanDeg    = 80;  // degrees between the two calibration points
  localparam int TempMax       = 255;
  localparam int TempMin       = -256;
  localparam int RunMax        = 255;
  localparam int WatchLimit    = 4000;
  localparam int DrainCycles   = 30;
  localparam int MaxReports    = 30;
  localparam int Phases        = 16;
  localparam int WordsPerPhase = 100;

  // register indexes past the end of the map, the block must ignore them
  localparam logic [CfgIdxW-1:0] CfgFreeLo = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgFreeHi = 3'd7;

  localparam logic signed [TempW-1:0] TempHi = TempW'(TempMax);
  localparam logic signed [TempW-1:0] TempLo = TempW'(TempMin);

  typedef struct packed {
    logic signed [TempW-1:0] temp;
    logic                    shutdown;
    logic                    clear_torque;
  } reading_t;

  typedef enum logic {RowSample, RowWrite} row_op_e;

  typedef struct packed {
    row_op_e            op;
    logic [CfgIdxW-1:0] idx;
    logic [CalW-1:0]    data;
    logic               pinned;
    reading_t           want;
  } dir_row_t;

  localparam reading_t Unpinned = '0;
  localparam reading_t AtBase   = '{otsm_pkg::TempBase, 1'b0, 1'b0};
  localparam reading_t HotIdle  = '{TempHi, 1'b0, 1'b0};
  localparam reading_t HotTrip  = '{TempHi, 1'b1, 1'b1};
  localparam reading_t ColdHeld = '{TempLo, 1'b1, 1'b0};
  localparam reading_t ColdIdle = '{TempLo, 1'b0, 1'b0};

  // directed part, reset calibration first (descending codes, span -440)
  dir_row_t dir_rows [39] = '{
    '{RowSample, '0, 12'd1750, 1'b1, AtBase},
    '{RowSample, '0, 12'd0, 1'b1, HotIdle},
    '{RowSample, '0, 12'd0, 1'b1, HotIdle},
    '{RowSample, '0, 12'd0, 1'b1, HotIdle},
    '{RowSample, '0, 12'd0, 1'b1, HotIdle},
    '{RowSample, '0, 12'd0, 1'b1, HotIdle},
    '{RowSample, '0, 12'd0, 1'b1, HotTrip},
    '{RowSample, '0, 12'd0, 1'b1, HotTrip},
    '{RowSample, '0, 12'd4095, 1'b1, ColdHeld},
    '{RowSample, '0, 12'd4095, 1'b1, ColdHeld},
    '{RowSample, '0, 12'd4095, 1'b1, ColdHeld},
    '{RowSample, '0, 12'd4095, 1'b1, ColdHeld},
    '{RowSample, '0, 12'd4095, 1'b1, ColdHeld},
    '{RowSample, '0, 12'd4095, 1'b1, ColdIdle},
    '{RowSample, '0, 12'd1751, 1'b1, AtBase},   // quotient rounds toward zero
    '{RowWrite, otsm_pkg::CfgCal110, 12'd1750, 1'b0, Unpinned},
    '{RowSample, '0, 12'd123, 1'b1, AtBase},    // zero span
    '{RowSample, '0, 12'd4095, 1'b1, AtBase},
    '{RowWrite, otsm_pkg::CfgTrip, 12'hFF6, 1'b0, Unpinned},
    '{RowWrite, otsm_pkg::CfgRelease, 12'hE64, 1'b0, Unpinned},
    '{RowWrite, otsm_pkg::CfgConfirm, 12'hF00, 1'b0, Unpinned},
    '{RowSample, '0, 12'd2000, 1'b0, Unpinned}, // hot and cold at once
    '{RowWrite, otsm_pkg::CfgConfirm, 12'h003, 1'b0, Unpinned},
    '{RowSample, '0, 12'd2000, 1'b0, Unpinned},
    '{RowWrite, CfgFreeLo, 12'hABC, 1'b0, Unpinned},
    '{RowWrite, CfgFreeHi, 12'h000, 1'b0, Unpinned},
    '{RowSample, '0, 12'd0, 1'b0, Unpinned},
    '{RowWrite, otsm_pkg::CfgConfirm, 12'h0FF, 1'b0, Unpinned},
    '{RowSample, '0, 12'd4095, 1'b0, Unpinned},
    '{RowWrite, otsm_pkg::CfgCal30, 12'd0, 1'b0, Unpinned},
    '{RowWrite, otsm_pkg::CfgCal110, 12'd4095, 1'b0, Unpinned},
    '{RowWrite, otsm_pkg::CfgTrip, 12'h0FF, 1'b0, Unpinned},
    '{RowWrite, otsm_pkg::CfgRelease, 12'h100, 1'b0, Unpinned},
    '{RowWrite, otsm_pkg::CfgConfirm, 12'h0FE, 1'b0, Unpinned},
    '{RowSample, '0, 12'd4095, 1'b0, Unpinned},
    '{RowWrite, otsm_pkg::CfgCal30, 12'd4095, 1'b0, Unpinned},
    '{RowWrite, otsm_pkg::CfgCal110, 12'd0, 1'b0, Unpinned},
    '{RowSample, '0, 12'd0, 1'b0, Unpinned},
    '{RowSample, '0, 12'd2048, 1'b0, Unpinned}
  };

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CfgIdxW-1:0]      cfg_idx = '0;
  logic [CalW-1:0]         cfg_wdata = '0;
  logic                    sample_valid = 1'b0;
  logic                    sample_ready;
  logic [SampleW-1:0]      sample_code = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [TempW-1:0] temp_celsius;
  logic                    shutdown;
  logic                    clear_torque;

  // predictor copy of the registers and the hysteresis state
  logic [CalW-1:0]         cal30_code = otsm_pkg::Cal30Rst;
  logic [CalW-1:0]         cal110_code = otsm_pkg::Cal110Rst;
  logic signed [TempW-1:0] trip_lvl = otsm_pkg::TripRst;
  logic signed [TempW-1:0] release_lvl = otsm_pkg::ReleaseRst;
  logic [RunW-1:0]         confirm_lvl = otsm_pkg::ConfirmRst;
  logic [RunW-1:0]         hot_cnt = '0;
  logic [RunW-1:0]         cool_cnt = '0;
  logic                    shut_flag = 1'b0;

  reading_t expected_readings [$];
  logic     pin_en = 1'b0;
  reading_t pin_want = '0;
  logic     tx_idle_en = 1'b1;
  logic     rx_idle_en = 1'b1;
  int       rx_hold = 0;
  int       quiet_cycles = 0;
  int       n_fail = 0;
  int       words_sent = 0;
  int       results_seen = 0;
  int       torque_clears = 0;
  int       cfg_writes = 0;
  int       settings_used = 0;

  overtemp_shutdown_monitor #(
    .SAMPLE_BITS(SampleW)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (sample_valid),
    .in_ready_o     (sample_ready),
    .sensor_sample_i(sample_code),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .temp_celsius_o (temp_celsius),
    .shutdown_o     (shutdown),
    .clear_torque_o (clear_torque)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic reading_t predict_reading(input logic [SampleW-1:0] code);
    longint   span;
    longint   t;
    reading_t r;
    span = longint'(cal110_code) - longint'(cal30_code);
    if (span == 0) begin
      t = otsm_pkg::TempBase;
    end else begin
      t = (longint'(code) - longint'(cal30_code)) * CalSpanDeg / span + otsm_pkg::TempBase;
      if (t > TempMax) t = TempMax;
      if (t < TempMin) t = TempMin;
    end
    r.temp = t[TempW-1:0];
    r.clear_torque = 1'b0;
    // hot rule goes first, so an overlapping cold rule can still release
    if (t > trip_lvl) begin
      if (hot_cnt != RunMax) hot_cnt++;
      if (hot_cnt > confirm_lvl) begin
        shut_flag = 1'b1;
        r.clear_torque = 1'b1;
      end
    end else begin
      hot_cnt = '0;
    end
    if (t < release_lvl) begin
      if (cool_cnt != RunMax) cool_cnt++;
      if (cool_cnt > confirm_lvl) shut_flag = 1'b0;
    end else begin
      cool_cnt = '0;
    end
    r.shutdown = shut_flag;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic check_field(input string what, input logic signed [TempW-1:0] want,
                             input logic signed [TempW-1:0] got);
    if (got !== want) begin
      if (n_fail < MaxReports)
        $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      n_fail++;
    end
  endtask

  // sampled at the rising edge: predict accepted words, check result words
  always @(posedge clk) begin
    reading_t want;
    if (rst_n) begin
      if (sample_valid && sample_ready) begin
        want = predict_reading(sample_code);
        if (pin_en) want = pin_want;
        expected_readings.push_back(want);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (clear_torque) torque_clears++;
        if (expected_readings.size() == 0) begin
          if (n_fail < MaxReports)
            $display("%0t: result word with nothing expected, got %0d/%b/%b", $time,
                     temp_celsius, shutdown, clear_torque);
          n_fail++;
        end else begin
          want = expected_readings.pop_front();
          check_field("temp_celsius", want.temp, temp_celsius);
          check_field("shutdown", TempW'(want.shutdown), TempW'(shutdown));
          check_field("clear_torque", TempW'(want.clear_torque), TempW'(clear_torque));
        end
      end
      if ((sample_valid && sample_ready) || (out_valid && out_ready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WatchLimit) begin
        $display("%0t: no word moved for %0d cycles", $time, WatchLimit);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (rx_hold != 0) begin
      out_ready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      out_ready <= 1'b1;
      if (rx_idle_en && $urandom_range(0, 4) == 0) rx_hold = pick_gap();
    end
  end

  task automatic push_sample(input logic [SampleW-1:0] code, input logic pin,
                             input reading_t want);
    pin_en = pin;
    pin_want = want;
    sample_valid <= 1'b1;
    sample_code <= code;
    do @(posedge clk); while (!sample_ready);
    @(negedge clk);
    pin_en = 1'b0;
    words_sent++;
  endtask

  task automatic idle_gap();
    int n;
    n = (tx_idle_en && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (n != 0) begin
      sample_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // hold off until every word in flight has come back
  task automatic settle();
    sample_valid <= 1'b0;
    while (expected_readings.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CalW-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      otsm_pkg::CfgCal30:   cal30_code = data;
      otsm_pkg::CfgCal110:  cal110_code = data;
      otsm_pkg::CfgTrip:    trip_lvl = data[TempW-1:0];
      otsm_pkg::CfgRelease: release_lvl = data[TempW-1:0];
      otsm_pkg::CfgConfirm: confirm_lvl = data[RunW-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic pick_setting(input int ph);
    logic [CalW-1:0]         c30;
    logic [CalW-1:0]         c110;
    logic [CalW-1:0]         junk;
    logic signed [TempW-1:0] trip;
    logic signed [TempW-1:0] rel;
    logic [RunW-1:0]         conf;
    case (ph % 5)
      0: begin
        c30 = CalW'($urandom_range(1600, 1900));
        c110 = c30 - CalW'($urandom_range(300, 600));
      end
      1: begin
        c30 = CalW'($urandom_range(0, 2000));
        c110 = c30 + CalW'($urandom_range(1, 2095));
      end
      2: begin
        c30 = CalW'($urandom);
        c110 = CalW'($urandom);
      end
      3: begin
        c30 = CalW'($urandom);
        c110 = c30;
      end
      default: begin
        // steep slope, mostly saturated readings
        c30 = CalW'($urandom_range(1, 4094));
        c110 = $urandom_range(0, 1) ? c30 + CalW'(1) : c30 - CalW'(1);
      end
    endcase
    if (ph % 3 == 2) begin
      trip = TempW'($urandom);
      rel = TempW'($urandom);
    end else begin
      trip = TempW'($urandom_range(20, 120));
      rel = trip - TempW'($urandom_range(0, 20));
    end
    case (ph)
      7:       conf = 8'd254;
      11:      conf = 8'd255;
      13:      conf = RunW'($urandom);
      default: conf = RunW'($urandom_range(0, 8));
    endcase
    junk = CalW'($urandom);
    write_reg(otsm_pkg::CfgCal30, c30);
    write_reg(otsm_pkg::CfgCal110, c110);
    write_reg(otsm_pkg::CfgTrip, {junk[CalW-1:TempW], trip});
    write_reg(otsm_pkg::CfgRelease, {junk[CalW-1:TempW], rel});
    write_reg(otsm_pkg::CfgConfirm, {junk[CalW-1:RunW], conf});
    if (ph % 4 == 1)
      write_reg(CfgIdxW'($urandom_range(CfgFreeLo, CfgFreeHi)), CalW'($urandom));
    settings_used++;
  endtask

  initial begin
    int phase_words;
    int run_len;
    int lim;
    int base;
    int code;
    int kind;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == RowWrite) begin
        settle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        push_sample(dir_rows[i].data, dir_rows[i].pinned, dir_rows[i].want);
        idle_gap();
      end
    end

    for (int ph = 0; ph < Phases; ph++) begin
      settle();
      pick_setting(ph);
      tx_idle_en = (ph % 4) != 2;
      rx_idle_en = (ph % 4) != 3;
      phase_words = 0;
      while (phase_words < WordsPerPhase) begin
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
          // a run of close readings, sometimes long enough to trip or release
          base = (kind == 0) ? ($urandom_range(0, 1) ? 4095 : 0) : $urandom_range(0, 4095);
          lim = (confirm_lvl < 20) ? int'(confirm_lvl) + 3 : 24;
          if (confirm_lvl >= 200 && $urandom_range(0, 1) == 0)
            run_len = $urandom_range(250, 300);
          else
            run_len = $urandom_range(1, lim);
          repeat (run_len) begin
            code = base + int'($urandom_range(0, 8)) - 4;
            if (code < 0) code = 0;
            if (code > 4095) code = 4095;
            push_sample(SampleW'(code), 1'b0, Unpinned);
            idle_gap();
            phase_words++;
          end
        end else begin
          push_sample(SampleW'($urandom), 1'b0, Unpinned);
          idle_gap();
          phase_words++;
        end
        if ($urandom_range(0, 39) == 0) settle();
      end
    end

    settle();
    repeat (DrainCycles) @(negedge clk);
    $display("sent %0d sensor words under %0d random settings plus the directed table",
             words_sent, settings_used);
    $display("checked %0d results, %0d clearing torque, %0d register writes",
             results_seen, torque_clears, cfg_writes);
    if (n_fail == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
